// ----- design/atdl_pkg.sv -----
package atdl_pkg;

   localparam int CORDIC_STEPS = 18;
   localparam int NUM_W        = 40;
   localparam int QLOW_W       = 21;
   localparam int ARG_W        = 22;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 18;

   localparam logic [19:0] ANGLE_TAB [CORDIC_STEPS] = '{
      20'd262144, 20'd154753, 20'd81767, 20'd41506, 20'd20834, 20'd10427,
      20'd5215,   20'd2608,   20'd1304,  20'd652,   20'd326,   20'd163,
      20'd81,     20'd41,     20'd20,    20'd10,    20'd5,     20'd3
   };

   localparam logic [22:0] DEG_PER_RAD_Q16     = 23'd3754936;
   localparam logic [18:0] RAD_PER_DEG_Q24     = 19'd292818;
   localparam logic [19:0] CORDIC_INV_GAIN_Q16 = 20'd39797;
   localparam logic [27:0] KD_RECIP            = 28'd214958286;
   localparam logic [14:0] KD_MAX              = 15'd18432;

   localparam logic [CSR_IDX_W-1:0] CSR_SLACK_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEG_ORIGIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARC_MIDPOINT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_BIAS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_FLOOR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_CEILING = 3'd5;

   typedef struct packed {
      logic signed [ARG_W-1:0] pos_arg;
      logic signed [ARG_W-1:0] hip_arg;
      logic [9:0]              pot;
   } side_type;

endpackage

// ----- design/atdl_div.sv -----
module atdl_div import atdl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [NUM_W-1:0]  in_num,
   input  logic [16:0]              in_mid,
   input  side_type                 in_side,
   output logic                     out_valid,
   output logic [QLOW_W-1:0]        out_quot,
   output logic                     out_neg,
   output side_type                 out_side
);

   logic [16:0] mid;

   logic              valid_ff [NUM_W];
   logic [16:0]       rem_ff   [NUM_W];
   logic [NUM_W-1:0]  dvd_ff   [NUM_W];
   logic [QLOW_W-1:0] quot_ff  [NUM_W];
   logic              neg_ff   [NUM_W];
   side_type          side_ff  [NUM_W];

   assign mid = (in_mid == 17'd0) ? 17'd1 : in_mid;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              v_p;
      logic [16:0]       rem_p;
      logic [NUM_W-1:0]  dvd_p;
      logic [QLOW_W-1:0] quot_p;
      logic              neg_p;
      side_type          side_p;
      logic [17:0]       shifted;
      logic              ge;
      logic [16:0]       rem_in;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign dvd_p  = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
         assign quot_p = '0;
         assign neg_p  = in_num[NUM_W-1];
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = valid_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign dvd_p  = dvd_ff[k-1];
         assign quot_p = quot_ff[k-1];
         assign neg_p  = neg_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign shifted = {rem_p, dvd_p[NUM_W-1]};
      assign ge      = shifted >= {1'b0, mid};
      assign rem_in  = ge ? 17'(shifted - {1'b0, mid}) : shifted[16:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_p;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            dvd_ff[k]  <= {dvd_p[NUM_W-2:0], 1'b0};
            quot_ff[k] <= {quot_p[QLOW_W-2:0], ge};
            neg_ff[k]  <= neg_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_neg   = neg_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ----- design/atdl_atan.sv -----
module atdl_atan import atdl_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [ARG_W-1:0] in_arg,
   output logic signed [ARG_W-1:0] out_angle
);

   localparam int L = CORDIC_STEPS;

   logic signed [31:0]      x_ff    [L+1];
   logic signed [31:0]      y_ff    [L+1];
   logic signed [ARG_W-1:0] z_ff    [L+1];
   logic                    neg_ff  [L+1];
   logic                    zero_ff [L+1];

   logic [ARG_W-1:0] mag;

   assign mag = in_arg[ARG_W-1] ? ARG_W'(-in_arg) : ARG_W'(in_arg);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= 32'sd65536;
         y_ff[0]    <= $signed(32'(mag) << 8);
         z_ff[0]    <= '0;
         neg_ff[0]  <= in_arg[ARG_W-1];
         zero_ff[0] <= (mag == '0);
      end
   end

   for (genvar k = 1; k <= L; k++) begin : g_iter
      logic signed [31:0]      x_in;
      logic signed [31:0]      y_in;
      logic signed [ARG_W-1:0] z_in;
      logic signed [ARG_W-1:0] ang;

      assign ang = $signed({2'b00, ANGLE_TAB[k-1]});

      always_comb begin
         if (y_ff[k-1] > 32'sd0) begin
            x_in = x_ff[k-1] + (y_ff[k-1] >>> (k-1));
            y_in = y_ff[k-1] - (x_ff[k-1] >>> (k-1));
            z_in = z_ff[k-1] + ang;
         end else begin
            x_in = x_ff[k-1] - (y_ff[k-1] >>> (k-1));
            y_in = y_ff[k-1] + (x_ff[k-1] >>> (k-1));
            z_in = z_ff[k-1] - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   assign out_angle = zero_ff[L] ? '0 : (neg_ff[L] ? -z_ff[L] : z_ff[L]);

endmodule

// ----- design/atdl_cos.sv -----
module atdl_cos import atdl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [QLOW_W-1:0]    in_quot,
   input  logic                 in_neg,
   input  logic [9:0]           in_pot,
   output logic                 out_valid,
   output logic signed [20:0]   out_cos,
   output logic [9:0]           out_pot
);

   localparam int L = CORDIC_STEPS;

   logic                valid_ff [L+1];
   logic signed [19:0]  x_ff     [L+1];
   logic signed [19:0]  y_ff     [L+1];
   logic signed [21:0]  z_ff     [L+1];
   logic                fold_ff  [L+1];
   logic [9:0]          pot_ff   [L+1];

   logic [QLOW_W-1:0] u;
   logic [QLOW_W-1:0] r;
   logic [QLOW_W-1:0] r_in;
   logic              fold_in;

   always_comb begin
      u       = in_neg ? QLOW_W'(-in_quot) : in_quot;
      r       = u[QLOW_W-1] ? QLOW_W'(-u) : u;
      fold_in = r > 21'd524288;
      r_in    = fold_in ? 21'(21'd1048576 - r) : r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= $signed(CORDIC_INV_GAIN_Q16);
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({1'b0, r_in});
         fold_ff[0] <= fold_in;
         pot_ff[0]  <= in_pot;
      end
   end

   for (genvar k = 1; k <= L; k++) begin : g_iter
      logic signed [19:0] x_in;
      logic signed [19:0] y_in;
      logic signed [21:0] z_in;
      logic signed [21:0] ang;

      assign ang = $signed({2'b00, ANGLE_TAB[k-1]});

      always_comb begin
         if (z_ff[k-1] >= 22'sd0) begin
            x_in = x_ff[k-1] - (y_ff[k-1] >>> (k-1));
            y_in = y_ff[k-1] + (x_ff[k-1] >>> (k-1));
            z_in = z_ff[k-1] - ang;
         end else begin
            x_in = x_ff[k-1] + (y_ff[k-1] >>> (k-1));
            y_in = y_ff[k-1] - (x_ff[k-1] >>> (k-1));
            z_in = z_ff[k-1] + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
            fold_ff[k] <= fold_ff[k-1];
            pot_ff[k]  <= pot_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[L];
   assign out_cos   = fold_ff[L] ? -21'(x_ff[L]) : 21'(x_ff[L]);
   assign out_pot   = pot_ff[L];

endmodule

// ----- design/assist_torque_and_damping_law.sv -----
// Pipeline: an accepted req beat passes through 3 front stages, 40 divider
// stages, 19 CORDIC stages, 4 back stages and the output register.
// Throughput: one beat per cycle while the skid stage is empty; the output
// register and skid stage keep req_tready high while one result waits. Reset
// clears all valid bits and loads the register defaults; no clearing pass.
module assist_torque_and_damping_law import atdl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // motor_position[16:0], imu_pitch[33:17], pot_reading[43:34], zero pad
   input  logic [47:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // torque_command[17:0], damping_command[32:18], zero pad
   output logic [39:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [16:0]        slack_ff;
   logic signed [16:0] leg_ff;
   logic [16:0]        mid_ff;
   logic signed [16:0] bias_ff;
   logic signed [17:0] tlo_ff;
   logic signed [17:0] thi_ff;

   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= '0;
         leg_ff   <= '0;
         mid_ff   <= 17'd4096;
         bias_ff  <= '0;
         tlo_ff   <= -18'sd73728;
         thi_ff   <= 18'sd73728;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLACK_WIDTH:    slack_ff <= csr_wdata[16:0];
            CSR_LEG_ORIGIN:     leg_ff   <= $signed(csr_wdata[16:0]);
            CSR_ARC_MIDPOINT:   mid_ff   <= csr_wdata[16:0];
            CSR_PITCH_BIAS:     bias_ff  <= $signed(csr_wdata[16:0]);
            CSR_TORQUE_FLOOR:   tlo_ff   <= $signed(csr_wdata);
            CSR_TORQUE_CEILING: thi_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // front stage 1
   logic signed [16:0] pos;
   logic signed [16:0] pitch;
   logic [16:0]        pmag;
   logic [9:0]         prnd;
   logic signed [19:0] psh;
   logic signed [19:0] hip_in;
   logic signed [19:0] d2_in;
   logic signed [17:0] dl_in;

   logic               f1_valid_ff;
   logic signed [19:0] hip_ff;
   logic signed [19:0] d2_ff;
   logic signed [17:0] dl_ff;
   logic [9:0]         f1_pot_ff;

   always_comb begin
      pos    = $signed(req_tdata[16:0]);
      pitch  = $signed(req_tdata[33:17]);
      pmag   = pitch[16] ? 17'(-pitch) : 17'(pitch);
      prnd   = 10'((18'(pmag) + 18'd128) >> 8);
      psh    = $signed({2'b00, prnd, 8'd0});
      hip_in = (pitch[16] ? -psh : psh) - 20'(bias_ff) - 20'sd512;
      d2_in  = 20'($signed({pos, 1'b0})) - $signed({3'b000, slack_ff});
      dl_in  = 18'(pos) - 18'(leg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= req_tvalid;
      end
      if (en) begin
         hip_ff    <= hip_in;
         d2_ff     <= d2_in;
         dl_ff     <= dl_in;
         f1_pot_ff <= req_tdata[43:34];
      end
   end

   // front stage 2
   logic signed [43:0] pprod_in;
   logic signed [39:0] hprod_in;

   logic               f2_valid_ff;
   logic signed [43:0] pprod_ff;
   logic signed [39:0] hprod_ff;
   logic signed [19:0] f2_hip_ff;
   logic signed [17:0] f2_dl_ff;
   logic [9:0]         f2_pot_ff;

   assign pprod_in = 44'(d2_ff) * 44'($signed({1'b0, DEG_PER_RAD_Q16}));
   assign hprod_in = 40'(hip_ff) * 40'($signed({1'b0, RAD_PER_DEG_Q24}));

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f2_valid_ff <= f1_valid_ff;
      end
      if (en) begin
         pprod_ff  <= pprod_in;
         hprod_ff  <= hprod_in;
         f2_hip_ff <= hip_ff;
         f2_dl_ff  <= dl_ff;
         f2_pot_ff <= f1_pot_ff;
      end
   end

   // front stage 3
   logic [43:0]             ppmag;
   logic [22:0]             pround;
   logic signed [23:0]      pdeg;
   logic signed [NUM_W-1:0] num_in;
   side_type                side_in;

   always_comb begin
      ppmag           = pprod_ff[43] ? 44'(-pprod_ff) : 44'(pprod_ff);
      pround          = 23'((ppmag + 44'd1048576) >> 21);
      pdeg            = pprod_ff[43] ? -$signed({1'b0, pround}) : $signed({1'b0, pround});
      num_in          = NUM_W'($signed({f2_dl_ff, 20'd0})) - NUM_W'(hprod_ff);
      side_in.pos_arg = ARG_W'(pdeg - 24'sd2560);
      side_in.hip_arg = ARG_W'(f2_hip_ff) - 22'sd5120;
      side_in.pot     = f2_pot_ff;
   end

   logic                    f3_valid_ff;
   logic signed [NUM_W-1:0] num_ff;
   side_type                f3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f3_valid_ff <= f2_valid_ff;
      end
      if (en) begin
         num_ff     <= num_in;
         f3_side_ff <= side_in;
      end
   end

   logic              dv_valid;
   logic [QLOW_W-1:0] dv_quot;
   logic              dv_neg;
   side_type          dv_side;

   atdl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f3_valid_ff),
      .in_num    (num_ff),
      .in_mid    (mid_ff),
      .in_side   (f3_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_neg   (dv_neg),
      .out_side  (dv_side)
   );

   logic signed [ARG_W-1:0] pos_angle;
   logic signed [ARG_W-1:0] hip_angle;
   logic                    cs_valid;
   logic signed [20:0]      cs_cos;
   logic [9:0]              cs_pot;

   atdl_atan u_atan_pos (
      .clock     (clock),
      .en        (en),
      .in_arg    (dv_side.pos_arg),
      .out_angle (pos_angle)
   );

   atdl_atan u_atan_hip (
      .clock     (clock),
      .en        (en),
      .in_arg    (dv_side.hip_arg),
      .out_angle (hip_angle)
   );

   atdl_cos u_cos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_quot   (dv_quot),
      .in_neg    (dv_neg),
      .in_pot    (dv_side.pot),
      .out_valid (cs_valid),
      .out_cos   (cs_cos),
      .out_pot   (cs_pot)
   );

   // back stage 1
   logic signed [24:0] t20_in;
   logic signed [21:0] fsum;
   logic [18:0]        fnum_in;
   logic [13:0]        gain_in;

   logic               b1_valid_ff;
   logic signed [24:0] t20_ff;
   logic [18:0]        fnum_ff;
   logic [13:0]        gain_ff;

   always_comb begin
      t20_in  = 25'(pos_angle) - (25'(hip_angle) <<< 2);
      fsum    = (22'(cs_cos) <<< 1) + 22'sd196608;
      fnum_in = fsum[21] ? 19'd0 : 19'(fsum);
      gain_in = 14'd4092 + 14'(cs_pot) * 14'd5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= cs_valid;
      end
      if (en) begin
         t20_ff  <= t20_in;
         fnum_ff <= fnum_in;
         gain_ff <= gain_in;
      end
   end

   // back stage 2
   logic [24:0]        tmag;
   logic [16:0]        tround;
   logic signed [17:0] tval;
   logic signed [17:0] torque_in;
   logic [32:0]        kprod_in;

   logic               b2_valid_ff;
   logic signed [17:0] torque_ff;
   logic [32:0]        kprod_ff;

   always_comb begin
      tmag     = t20_ff[24] ? 25'(-t20_ff) : 25'(t20_ff);
      tround   = 17'((tmag + 25'd128) >> 8);
      tval     = t20_ff[24] ? -$signed({1'b0, tround}) : $signed({1'b0, tround});
      priority if (tval < tlo_ff) begin
         torque_in = tlo_ff;
      end else if (tval > thi_ff) begin
         torque_in = thi_ff;
      end else begin
         torque_in = tval;
      end
      kprod_in = 33'(gain_ff) * 33'(fnum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (en) begin
         b2_valid_ff <= b1_valid_ff;
      end
      if (en) begin
         torque_ff <= torque_in;
         kprod_ff  <= kprod_in;
      end
   end

   // back stage 3
   logic               b3_valid_ff;
   logic signed [17:0] b3_torque_ff;
   logic [26:0]        kscaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else if (en) begin
         b3_valid_ff <= b2_valid_ff;
      end
      if (en) begin
         b3_torque_ff <= torque_ff;
         kscaled_ff   <= 27'((kprod_ff + 33'd81840) >> 5);
      end
   end

   // back stage 4: divide by 5115 through the reciprocal
   logic               b4_valid_ff;
   logic signed [17:0] b4_torque_ff;
   logic [54:0]        kquot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_valid_ff <= 1'b0;
      end else if (en) begin
         b4_valid_ff <= b3_valid_ff;
      end
      if (en) begin
         b4_torque_ff <= b3_torque_ff;
         kquot_ff     <= 55'(kscaled_ff) * 55'(KD_RECIP);
      end
   end

   logic [14:0] kd_raw;
   logic [32:0] beat_in;

   assign kd_raw  = kquot_ff[54:40];
   assign beat_in = {(kd_raw > KD_MAX) ? KD_MAX : kd_raw, b4_torque_ff};

   // output register and skid stage
   logic        rsp_valid_ff;
   logic [32:0] rsp_data_ff;
   logic        skid_valid_ff;
   logic [32:0] skid_data_ff;
   logic        out_take;

   assign en       = !skid_valid_ff;
   assign out_take = rsp_tready || !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_take) begin
         rsp_valid_ff <= b4_valid_ff;
      end else if (b4_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (out_take) begin
         rsp_data_ff <= beat_in;
      end else begin
         skid_data_ff <= beat_in;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   a_skid_has_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds a beat while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("skid beat lost while output stalled");

   a_kd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[32:18] <= KD_MAX)
      else $error("damping beyond saturation limit");

endmodule
